/* rtl/core/u2a_pkg.sv */
// u2a_pkg: shared types and the latin transliteration table for the
// utf-8 to ascii transliterator. no dependencies.
package u2a_pkg;

  typedef struct packed {
    logic [1:0] skip_remaining;
    logic       expect_second;
    logic       halted;
  } state_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       char_valid;
    logic       last_result;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } dec_t;

  localparam logic [6:0] NO_CHAR = 7'h00;

  // returns {first, second}; second is NO_CHAR for single-character entries
  function automatic logic [13:0] xlat(input logic [5:0] idx);
    logic [13:0] e;
    unique case (idx)
      6'd0, 6'd1, 6'd2, 6'd3, 6'd5: e = {7'h41, NO_CHAR};
      6'd4:                          e = {7'h41, 7'h65};
      6'd6:                          e = {7'h41, 7'h45};
      6'd7:                          e = {7'h43, NO_CHAR};
      6'd8, 6'd9, 6'd10, 6'd11:      e = {7'h45, NO_CHAR};
      6'd12, 6'd13, 6'd14, 6'd15:    e = {7'h49, NO_CHAR};
      6'd16:                         e = {7'h44, NO_CHAR};
      6'd17:                         e = {7'h4E, NO_CHAR};
      6'd18, 6'd19, 6'd20, 6'd21,
      6'd24:                         e = {7'h4F, NO_CHAR};
      6'd22:                         e = {7'h4F, 7'h65};
      6'd23:                         e = {7'h2A, NO_CHAR};
      6'd25, 6'd26, 6'd27:           e = {7'h55, NO_CHAR};
      6'd28:                         e = {7'h55, 7'h65};
      6'd29:                         e = {7'h59, NO_CHAR};
      6'd30:                         e = {7'h50, NO_CHAR};
      6'd31:                         e = {7'h73, 7'h73};
      6'd32, 6'd33, 6'd34, 6'd35,
      6'd37:                         e = {7'h61, NO_CHAR};
      6'd36, 6'd38:                  e = {7'h61, 7'h65};
      6'd39:                         e = {7'h63, NO_CHAR};
      6'd40, 6'd41, 6'd42, 6'd43:    e = {7'h65, NO_CHAR};
      6'd44, 6'd45, 6'd46, 6'd47:    e = {7'h69, NO_CHAR};
      6'd48:                         e = {7'h64, NO_CHAR};
      6'd49:                         e = {7'h6E, NO_CHAR};
      6'd50, 6'd51, 6'd52, 6'd53,
      6'd56:                         e = {7'h6F, NO_CHAR};
      6'd54:                         e = {7'h6F, 7'h65};
      6'd55:                         e = {7'h2F, NO_CHAR};
      6'd57, 6'd58, 6'd59:           e = {7'h75, NO_CHAR};
      6'd60:                         e = {7'h75, 7'h65};
      6'd61, 6'd63:                  e = {7'h79, NO_CHAR};
      6'd62:                         e = {7'h70, NO_CHAR};
      default:                       e = {NO_CHAR, NO_CHAR};
    endcase
    return e;
  endfunction

endpackage

/* rtl/core/u2a_in_if.sv */
// u2a_in_if: valid/ready channel carrying one utf-8 text byte per transaction.
// no dependencies.
interface u2a_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source(output valid, output text_byte, output last_byte, input ready);
  modport sink(input valid, input text_byte, input last_byte, output ready);
endinterface

/* rtl/core/u2a_out_if.sv */
// u2a_out_if: valid/ready channel carrying one ascii result per transaction.
// no dependencies.
interface u2a_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       char_valid;
  logic       last_result;

  modport source(output valid, output out_char, output char_valid, output last_result,
                 input ready);
  modport sink(input valid, input out_char, input char_valid, input last_result,
               output ready);
endinterface

/* rtl/core/u2a_decode.sv */
// u2a_decode: combinational utf-8 byte decoder, gives up to two results and
// the next decoder state. depends on u2a_pkg.
module u2a_decode (
  input  logic [7:0]      text_byte,
  input  logic            last_byte,
  input  u2a_pkg::state_t state,
  output u2a_pkg::state_t state_next,
  output u2a_pkg::dec_t   dec
);

  logic [13:0] entry;
  logic [1:0]  n;
  logic [6:0]  c0;
  logic [6:0]  c1;

  assign entry = u2a_pkg::xlat(text_byte[5:0]);

  always_comb begin
    state_next = state;
    n          = 2'd0;
    c0         = u2a_pkg::NO_CHAR;
    c1         = u2a_pkg::NO_CHAR;
    priority if (state.halted) begin
      // consume silently
    end else if (text_byte == 8'h00) begin
      state_next.halted         = 1'b1;
      state_next.skip_remaining = 2'd0;
      state_next.expect_second  = 1'b0;
    end else if (state.skip_remaining != 2'd0) begin
      state_next.skip_remaining = state.skip_remaining - 2'd1;
    end else if (state.expect_second) begin
      state_next.expect_second = 1'b0;
      if (text_byte[7:6] == 2'b10) begin
        c0 = entry[13:7];
        c1 = entry[6:0];
        n  = (entry[6:0] != u2a_pkg::NO_CHAR) ? 2'd2 : 2'd1;
      end
    end else if (!text_byte[7]) begin
      c0 = text_byte[6:0];
      n  = 2'd1;
    end else if (text_byte[7:5] == 3'b110) begin
      state_next.expect_second = 1'b1;
    end else if (text_byte[7:4] == 4'b1110) begin
      state_next.skip_remaining = 2'd2;
    end else if (text_byte[7:3] == 5'b11110) begin
      state_next.skip_remaining = 2'd3;
    end else begin
      state_next.halted = 1'b1;
    end

    if (last_byte) begin
      state_next = '0;
    end

    dec.r0.out_char    = c0;
    dec.r0.char_valid  = (n != 2'd0);
    dec.r0.last_result = last_byte && (n != 2'd2);
    dec.r1.out_char    = c1;
    dec.r1.char_valid  = 1'b1;
    dec.r1.last_result = last_byte;
    // end-only result when the final byte carries no character
    dec.count = (last_byte && n == 2'd0) ? 2'd1 : n;
  end

endmodule

/* rtl/core/utf8_to_ascii_transliterator_unit.sv */
// utf8_to_ascii_transliterator_unit: top level, input register, decoder,
// output register with a holding slot. depends on u2a_pkg, u2a_in_if,
// u2a_out_if and u2a_decode.
// the first result passes through the input register, then the result
// register. throughput: one byte per cycle while the output accepts; a
// byte that expands to two characters holds off the next result-bearing
// byte until the single result register takes the held second character.
// synchronous active-high reset clears the decoder state and all valid flags.
module utf8_to_ascii_transliterator_unit (
  input  logic clk,
  input  logic rst,
  u2a_in_if.sink    text_in,
  u2a_out_if.source char_out
);

  logic            a_valid;
  logic [7:0]      a_byte;
  logic            a_last;
  u2a_pkg::state_t state;
  u2a_pkg::state_t state_next;
  u2a_pkg::dec_t   dec;
  logic            out_valid;
  u2a_pkg::res_t   out_res;
  logic            hold_valid;
  u2a_pkg::res_t   hold_res;
  logic            out_free;
  logic            a_move;

  u2a_decode u_decode (
    .text_byte  (a_byte),
    .last_byte  (a_last),
    .state      (state),
    .state_next (state_next),
    .dec        (dec)
  );

  assign out_free = !out_valid || char_out.ready;
  // a byte with no result leaves even when the output side is stalled
  assign a_move   = a_valid && ((dec.count == 2'd0) || (!hold_valid && out_free));

  assign text_in.ready        = !a_valid || a_move;
  assign char_out.valid       = out_valid;
  assign char_out.out_char    = out_res.out_char;
  assign char_out.char_valid  = out_res.char_valid;
  assign char_out.last_result = out_res.last_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
      state      <= '0;
    end else begin
      if (text_in.valid && text_in.ready) begin
        a_valid <= 1'b1;
        a_byte  <= text_in.text_byte;
        a_last  <= text_in.last_byte;
      end else if (a_move) begin
        a_valid <= 1'b0;
      end

      if (a_move) begin
        state <= state_next;
      end

      if (out_free) begin
        if (hold_valid) begin
          out_res    <= hold_res;
          out_valid  <= 1'b1;
          hold_valid <= 1'b0;
        end else if (a_move && dec.count != 2'd0) begin
          out_res   <= dec.r0;
          out_valid <= 1'b1;
          if (dec.count == 2'd2) begin
            hold_res   <= dec.r1;
            hold_valid <= 1'b1;
          end
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

endmodule

/* sim/tb_checker.sv */
// tb_checker: watches the text and result channels of the transliterator,
// predicts every result from the accepted text bytes and compares them.
// depends on u2a_pkg, u2a_in_if and u2a_out_if.
module tb_checker (
  input  logic clk,
  input  logic rst,
  u2a_in_if    text_mon,
  u2a_out_if   char_mon,
  output int   fail_count,
  output int   pending,
  output int   checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;
  localparam logic [7:0] NO_SECOND  = 8'h20;

  // latin-1 supplement 0xc0..0xff, indexed by the continuation byte's low six bits
  localparam logic [8*64-1:0] FIRST_CHARS =
    "AAAAAAACEEEEIIIIDNOOOOO*OUUUUYPsaaaaaaaceeeeiiiidnooooo/ouuuuypy";
  localparam logic [8*64-1:0] SECOND_CHARS =
    "    e E               e     e  s    e e               e     e   ";

  logic [1:0]      skip_left;
  logic            want_second;
  logic            stopped;
  u2a_pkg::res_t   expected_q[$];
  int              n_fail;
  int              n_checked;

  function automatic logic [7:0] table_char(input logic [8*64-1:0] tbl, input logic [5:0] idx);
    return tbl[8*(63 - idx) +: 8];
  endfunction

  task automatic transliterate(input logic [7:0] b, input logic fin);
    logic [7:0]    chars [0:1];
    int            n;
    u2a_pkg::res_t r;
    n = 0;
    if (stopped) begin
      // everything up to the end of the text is swallowed
    end else if (b == 8'h00) begin
      stopped     = 1'b1;
      skip_left   = 2'd0;
      want_second = 1'b0;
    end else if (skip_left != 2'd0) begin
      skip_left = skip_left - 2'd1;
    end else if (want_second) begin
      want_second = 1'b0;
      if ((b & CONT_MASK) == CONT_TAG) begin
        chars[0] = table_char(FIRST_CHARS, b[5:0]);
        n = 1;
        if (table_char(SECOND_CHARS, b[5:0]) != NO_SECOND) begin
          chars[1] = table_char(SECOND_CHARS, b[5:0]);
          n = 2;
        end
      end
    end else if (!b[7]) begin
      chars[0] = b;
      n = 1;
    end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
      want_second = 1'b1;
    end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
      skip_left = 2'd2;
    end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
      skip_left = 2'd3;
    end else begin
      stopped = 1'b1;
    end

    for (int k = 0; k < n; k++) begin
      r.out_char    = chars[k][6:0];
      r.char_valid  = 1'b1;
      r.last_result = fin && (k == n - 1);
      expected_q.push_back(r);
    end
    if (fin) begin
      if (n == 0) begin
        r.out_char    = u2a_pkg::NO_CHAR;
        r.char_valid  = 1'b0;
        r.last_result = 1'b1;
        expected_q.push_back(r);
      end
      skip_left   = 2'd0;
      want_second = 1'b0;
      stopped     = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    u2a_pkg::res_t want;
    if (rst) begin
      skip_left   = 2'd0;
      want_second = 1'b0;
      stopped     = 1'b0;
      expected_q.delete();
    end else begin
      if (char_mon.valid && char_mon.ready) begin
        n_checked++;
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction: out_char %h char_valid %b last_result %b",
                 char_mon.out_char, char_mon.char_valid, char_mon.last_result);
          n_fail++;
        end else begin
          want = expected_q.pop_front();
          if (char_mon.out_char !== want.out_char) begin
            $error("out_char: expected %h, actual %h", want.out_char, char_mon.out_char);
            n_fail++;
          end
          if (char_mon.char_valid !== want.char_valid) begin
            $error("char_valid: expected %b, actual %b", want.char_valid, char_mon.char_valid);
            n_fail++;
          end
          if (char_mon.last_result !== want.last_result) begin
            $error("last_result: expected %b, actual %b", want.last_result,
                   char_mon.last_result);
            n_fail++;
          end
        end
      end
      if (text_mon.valid && text_mon.ready) begin
        transliterate(text_mon.text_byte, text_mon.last_byte);
      end
    end
    fail_count <= n_fail;
    pending    <= expected_q.size();
    checked    <= n_checked;
  end

endmodule

/* sim/tb_top.sv */
// tb_top: clock, reset and stimulus for utf8_to_ascii_transliterator_unit,
// with random idling on both channels. depends on u2a_pkg, u2a_in_if,
// u2a_out_if, tb_checker and the block itself.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 750;
  localparam int STALL_PCT    = 10;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } text_item_t;

  logic clk;
  logic rst;

  u2a_in_if  text_ch ();
  u2a_out_if char_ch ();

  int fail_count;
  int pending;
  int checked;

  text_item_t stim_q[$];
  int         next_idx    = 0;
  int         sent_count  = 0;
  int         idle_cycles = 0;
  int         text_count  = 0;
  logic       calm;

  utf8_to_ascii_transliterator_unit uut (
    .clk      (clk),
    .rst      (rst),
    .text_in  (text_ch),
    .char_out (char_ch)
  );

  tb_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .text_mon   (text_ch),
    .char_mon   (char_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  task automatic add_byte(input logic [7:0] b, input logic fin = 1'b0);
    text_item_t t;
    t.text_byte = b;
    t.last_byte = fin;
    stim_q.push_back(t);
    if (fin) text_count++;
  endtask

  // mostly well-formed utf-8 with random content, a little raw noise
  task automatic add_random_text();
    int n_chars;
    int kind;
    int c;
    n_chars = $urandom_range(12, 1);
    for (c = 0; c < n_chars; c++) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        add_byte(8'($urandom_range(127, 1)));
      end else if (kind < 72) begin
        add_byte(8'($urandom_range(8'hDF, 8'hC0)));
        add_byte(8'($urandom_range(8'hBF, 8'h80)));
      end else if (kind < 82) begin
        add_byte(8'($urandom_range(8'hEF, 8'hE0)));
        add_byte(8'($urandom_range(8'hBF, 8'h80)));
        add_byte(8'($urandom_range(8'hBF, 8'h80)));
      end else if (kind < 90) begin
        add_byte(8'($urandom_range(8'hF7, 8'hF0)));
        add_byte(8'($urandom_range(8'hBF, 8'h80)));
        add_byte(8'($urandom_range(8'hBF, 8'h80)));
        add_byte(8'($urandom_range(8'hBF, 8'h80)));
      end else begin
        add_byte(8'($urandom_range(255, 0)));
      end
    end
    stim_q[stim_q.size() - 1].last_byte = 1'b1;
    text_count++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  assign calm = (sent_count >= 300) && (sent_count < 500);

  always @(posedge clk) begin
    if (rst) begin
      text_ch.valid <= 1'b0;
    end else if (!text_ch.valid || text_ch.ready) begin
      if (next_idx < stim_q.size() && (calm || $urandom_range(99) >= STALL_PCT)) begin
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= stim_q[next_idx].text_byte;
        text_ch.last_byte <= stim_q[next_idx].last_byte;
        next_idx          <= next_idx + 1;
      end else begin
        text_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      char_ch.ready <= 1'b0;
    end else begin
      char_ch.ready <= calm || ($urandom_range(99) >= STALL_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && text_ch.valid && text_ch.ready) sent_count <= sent_count + 1;
  end

  // watchdog on cycles where neither channel completes a transaction
  always @(posedge clk) begin
    if (rst || (text_ch.valid && text_ch.ready) || (char_ch.valid && char_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  initial begin
    int n_directed;
    rst = 1'b1;

    // plain ascii at the top of the range
    add_byte(8'h41);
    add_byte(8'h7F);
    // two-byte sequences: two-char entry, last table entry, two chars ending the text
    add_byte(8'hC3);
    add_byte(8'h84);
    add_byte(8'hDF);
    add_byte(8'hBF);
    add_byte(8'hC3);
    add_byte(8'h9F, 1'b1);
    // second byte outside the continuation range is swallowed
    add_byte(8'hC3);
    add_byte(8'h41);
    // three- and four-byte sequences skipped whole
    add_byte(8'hE2);
    add_byte(8'h82);
    add_byte(8'hAC);
    add_byte(8'hF0);
    add_byte(8'h9F);
    add_byte(8'h98);
    add_byte(8'h80);
    // stray continuation halts until the end, end-only result
    add_byte(8'h80);
    add_byte(8'h7A, 1'b1);
    // zero as a second byte halts
    add_byte(8'hC3);
    add_byte(8'h00);
    add_byte(8'h71, 1'b1);
    // 0xf8..0xff leads are malformed
    add_byte(8'hF8);
    add_byte(8'hFF, 1'b1);
    // zero inside a skip, then lowest ascii as a one-byte text
    add_byte(8'hE2);
    add_byte(8'h00, 1'b1);
    add_byte(8'h01, 1'b1);
    n_directed = stim_q.size();

    while (stim_q.size() < n_directed + RANDOM_ITEMS) add_random_text();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (sent_count < stim_q.size()) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d text bytes in %0d texts sent, %0d results checked",
             sent_count, text_count, checked);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/u2a_pkg.sv
rtl/core/u2a_in_if.sv
rtl/core/u2a_out_if.sv
rtl/core/u2a_decode.sv
rtl/core/utf8_to_ascii_transliterator_unit.sv
sim/tb_checker.sv
sim/tb_top.sv
